### sv/ipv4_forward_route_lookup_assert.svh
// assertion macros for the route lookup checker
// no dependencies; included by the checker file
`ifndef IPV4_FORWARD_ROUTE_LOOKUP_ASSERT_SVH
`define IPV4_FORWARD_ROUTE_LOOKUP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define IPFRL_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define IPFRL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/ipfrl_pkg.sv
// shared types, constants and helper functions for the ipv4 route lookup
// no dependencies
`timescale 1ns / 1ps

package ipfrl_pkg;

   localparam int ROUTE_ENTRIES = 64;
   localparam int ROUTE_AW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
   localparam int COUNT_W = $clog2(ROUTE_ENTRIES + 1);

   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_ADD    = 2'd1;
   localparam logic [1:0] MODE_HEADER = 2'd2;

   localparam logic [1:0] ACT_FORWARD  = 2'd0;
   localparam logic [1:0] ACT_LOCAL    = 2'd1;
   localparam logic [1:0] ACT_EXPIRED  = 2'd2;
   localparam logic [1:0] ACT_NO_ROUTE = 2'd3;

   localparam logic [4:0] POS_TTL    = 5'd4;
   localparam logic [4:0] POS_CKSUM  = 5'd5;
   localparam logic [4:0] POS_DST_HI = 5'd8;
   localparam logic [4:0] POS_DST_LO = 5'd9;
   localparam logic [4:0] POS_LIMIT  = 5'd31;

   localparam logic [5:0] MAX_PREFIX_LEN = 6'd32;

   typedef struct packed {
      logic [31:0] prefix;
      logic [5:0]  length;
      logic [31:0] hop;
   } route_entry_type;

   typedef struct packed {
      logic [7:0]  ttl;
      logic [31:0] destination;
      logic [15:0] checksum;
   } hdr_status_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DECIDE = 3'b010,
      ST_SEARCH = 3'b100
   } lookup_state_type;

   // length is already clamped to 32 when stored
   function automatic logic [31:0] prefix_mask(input logic [5:0] len);
      logic [31:0] m;
      if (len == 6'd0) begin
         m = 32'h0;
      end else if (len >= MAX_PREFIX_LEN) begin
         m = 32'hffff_ffff;
      end else begin
         m = 32'hffff_ffff << (6'd32 - len);
      end
      return m;
   endfunction

   // two end-around folds are enough for a 21-bit sum
   function automatic logic [15:0] fold_checksum(input logic [20:0] sum);
      logic [16:0] s1;
      logic [16:0] s2;
      s1 = {1'b0, sum[15:0]} + {12'd0, sum[20:16]};
      s2 = {1'b0, s1[15:0]} + {16'd0, s1[16]};
      return ~s2[15:0];
   endfunction

endpackage

### sv/ipv4_forward_route_lookup.sv
// ipv4 forwarding decision: route table, header accumulator and search sequencer
// depends on ipfrl_pkg, ipfrl_route_ram, ipfrl_header
//
// usage:
//   req_* carries one item per transfer: clear table, add route, or one 16-bit
//   header word. an item is taken when req_valid is high and req_stall low.
//   clear, add and non-final header words never stall the input.
//   the final header word (req_header_last) raises req_stall for the decide
//   state, then the route table is walked one entry per cycle from its
//   synchronous ram, whose read data is registered.
//   ttl expired and local delivery skip the walk and finish in the decide state.
//   rsp_* holds one result in an output register; it leaves when rsp_stall is
//   low. while it waits the block keeps taking items; a new result waits in
//   the sequencer (req_stall stays high) until the register frees up.
//   csr_local_address is written through csr_valid/csr_ready, always ready.
//   reset empties the table, clears the overflow flag, the local address and
//   any header in progress; table contents are not cleared.
`timescale 1ns / 1ps

module ipv4_forward_route_lookup (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_route_dest,
   input  logic [5:0]  req_route_prefix_len,
   input  logic [31:0] req_route_next_hop,
   input  logic [15:0] req_header_word,
   input  logic        req_header_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_action,
   output logic [31:0] rsp_next_hop,
   output logic [7:0]  rsp_new_ttl,
   output logic [15:0] rsp_new_checksum,
   output logic        rsp_table_overflow,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_local_address
);
   import ipfrl_pkg::*;

   lookup_state_type state_ff, state_in;

   logic [31:0]        local_addr_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               overflow_ff, overflow_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic               cmp_valid_ff, cmp_valid_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         action_ff, action_in;
   logic [31:0]        hop_ff, hop_in;
   logic [7:0]         ttl_ff, ttl_in;
   logic [15:0]        csum_ff, csum_in;
   logic               ovf_ff, ovf_in;

   logic               req_xfer;
   logic               is_add, is_header;
   logic               out_free;
   logic               result_load;
   logic               hdr_clear;
   logic               issue_ok, hit, match, finish, rd_en;
   logic               ram_wr_en;
   logic [31:0]        mask;
   route_entry_type    wr_entry;
   route_entry_type    rd_entry;
   hdr_status_type     hdr;

   assign req_xfer  = req_valid && !req_stall;
   assign is_add    = req_mode == MODE_ADD;
   assign is_header = req_mode == MODE_HEADER;
   assign req_stall = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_addr_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         local_addr_ff <= csr_local_address;
      end
   end

   // route table writes
   assign ram_wr_en = req_xfer && is_add && (count_ff < COUNT_W'(ROUTE_ENTRIES));
   assign wr_entry.prefix = req_route_dest;
   assign wr_entry.length = (req_route_prefix_len > MAX_PREFIX_LEN) ?
                            MAX_PREFIX_LEN : req_route_prefix_len;
   assign wr_entry.hop    = req_route_next_hop;

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (req_xfer && req_mode == MODE_CLEAR) begin
         count_in = '0;
      end else if (req_xfer && is_add) begin
         if (ram_wr_en) begin
            count_in = count_ff + COUNT_W'(1);
         end else begin
            overflow_in = 1'b1;
         end
      end
   end

   ipfrl_route_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[ROUTE_AW-1:0]),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[ROUTE_AW-1:0]),
      .rd_data (rd_entry)
   );

   ipfrl_header u_header (
      .clock   (clock),
      .reset   (reset),
      .word_en (req_xfer && is_header),
      .word    (req_header_word),
      .clear   (hdr_clear),
      .status  (hdr)
   );

   // search pipeline: issue entry idx, compare it in the following cycle
   assign mask     = prefix_mask(rd_entry.length);
   assign hit      = (rd_entry.prefix & mask) == (hdr.destination & mask);
   assign match    = cmp_valid_ff && hit;
   assign issue_ok = idx_ff < count_ff;
   assign finish   = match || !issue_ok;
   assign rd_en    = (state_ff == ST_SEARCH) && !finish;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmp_valid_in = cmp_valid_ff;
      result_load  = 1'b0;
      action_in    = ACT_NO_ROUTE;
      hop_in       = '0;
      ttl_in       = '0;
      csum_in      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && is_header && req_header_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (hdr.ttl == 8'd0 || hdr.destination == local_addr_ff) begin
               action_in = (hdr.ttl == 8'd0) ? ACT_EXPIRED : ACT_LOCAL;
               if (out_free) begin
                  result_load = 1'b1;
                  state_in    = ST_IDLE;
               end
            end else begin
               idx_in       = '0;
               cmp_valid_in = 1'b0;
               state_in     = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (finish) begin
               if (match) begin
                  action_in = ACT_FORWARD;
                  hop_in    = rd_entry.hop;
                  ttl_in    = hdr.ttl - 8'd1;
                  csum_in   = hdr.checksum;
               end
               if (out_free) begin
                  result_load = 1'b1;
                  state_in    = ST_IDLE;
               end
            end else begin
               idx_in       = idx_ff + COUNT_W'(1);
               cmp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign hdr_clear = result_load;
   assign ovf_in    = overflow_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         idx_ff       <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         idx_ff       <= idx_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         action_ff <= action_in;
         hop_ff    <= hop_in;
         ttl_ff    <= ttl_in;
         csum_ff   <= csum_in;
         ovf_ff    <= ovf_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_action         = action_ff;
   assign rsp_next_hop       = hop_ff;
   assign rsp_new_ttl        = ttl_ff;
   assign rsp_new_checksum   = csum_ff;
   assign rsp_table_overflow = ovf_ff;

endmodule

### sv/ipfrl_route_ram.sv
// route table storage: one write port, one registered read port
// depends on ipfrl_pkg
`timescale 1ns / 1ps

module ipfrl_route_ram (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [ipfrl_pkg::ROUTE_AW-1:0]  wr_addr,
   input  ipfrl_pkg::route_entry_type      wr_data,
   input  logic                            rd_en,
   input  logic [ipfrl_pkg::ROUTE_AW-1:0]  rd_addr,
   output ipfrl_pkg::route_entry_type      rd_data
);
   import ipfrl_pkg::*;

   route_entry_type mem [ROUTE_ENTRIES];
   route_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/ipfrl_header.sv
// header word accumulator: position, checksum sum, ttl and destination
// depends on ipfrl_pkg
`timescale 1ns / 1ps

module ipfrl_header (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      word_en,
   input  logic [15:0]               word,
   input  logic                      clear,
   output ipfrl_pkg::hdr_status_type status
);
   import ipfrl_pkg::*;

   logic [4:0]  pos_ff, pos_in;
   logic [20:0] sum_ff, sum_in;
   logic [31:0] dest_ff, dest_in;
   logic [7:0]  ttl_ff, ttl_in;
   logic [7:0]  ttl_dec;

   assign ttl_dec = word[15:8] - 8'd1;

   always_comb begin
      pos_in  = pos_ff;
      sum_in  = sum_ff;
      dest_in = dest_ff;
      ttl_in  = ttl_ff;
      if (clear) begin
         pos_in  = '0;
         sum_in  = '0;
         dest_in = '0;
         ttl_in  = '0;
      end else if (word_en && pos_ff != POS_LIMIT) begin
         pos_in = pos_ff + 5'd1;
         if (pos_ff == POS_TTL) begin
            ttl_in = word[15:8];
            sum_in = sum_ff + {5'd0, ttl_dec, word[7:0]};
         end else if (pos_ff == POS_CKSUM) begin
            // checksum field counts as zero
            sum_in = sum_ff;
         end else begin
            if (pos_ff == POS_DST_HI) begin
               dest_in = {word, dest_ff[15:0]};
            end else if (pos_ff == POS_DST_LO) begin
               dest_in = {dest_ff[31:16], word};
            end
            sum_in = sum_ff + {5'd0, word};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         sum_ff  <= '0;
         dest_ff <= '0;
         ttl_ff  <= '0;
      end else begin
         pos_ff  <= pos_in;
         sum_ff  <= sum_in;
         dest_ff <= dest_in;
         ttl_ff  <= ttl_in;
      end
   end

   assign status.ttl         = ttl_ff;
   assign status.destination = dest_ff;
   assign status.checksum    = fold_checksum(sum_ff);

endmodule

### sv/ipfrl_checker.sv
// port-level checker for the route lookup, bound to the top level
// depends on ipfrl_pkg and ipv4_forward_route_lookup_assert.svh
`timescale 1ns / 1ps
`include "ipv4_forward_route_lookup_assert.svh"

module ipfrl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_mode,
   input logic        req_header_last,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_action,
   input logic [31:0] rsp_next_hop,
   input logic [7:0]  rsp_new_ttl,
   input logic [15:0] rsp_new_checksum
);
   import ipfrl_pkg::*;

   // only a forwarded header carries hop, ttl and checksum
   `IPFRL_ASSERT_IMPLY(a_zero_unless_forward, clock, reset,
      rsp_valid && rsp_action != ACT_FORWARD,
      rsp_next_hop == 32'd0 && rsp_new_ttl == 8'd0 && rsp_new_checksum == 16'd0,
      "non-forward result carries hop, ttl or checksum")

   // the final header word is always followed by a stall in the decide state
   `IPFRL_ASSERT_NEXT(a_last_word_stalls, clock, reset,
      req_valid && !req_stall && req_mode == MODE_HEADER && req_header_last,
      req_stall,
      "input not stalled after the final header word")

   // a new result only comes out of a lookup in progress
   `IPFRL_ASSERT_IMPLY(a_result_after_lookup, clock, reset,
      $rose(rsp_valid),
      $past(req_stall),
      "result appeared without a lookup")

   `IPFRL_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_action) && $stable(rsp_next_hop),
      "stalled result changed")

endmodule

bind ipv4_forward_route_lookup ipfrl_checker u_ipfrl_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_mode         (req_mode),
   .req_header_last  (req_header_last),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_action       (rsp_action),
   .rsp_next_hop     (rsp_next_hop),
   .rsp_new_ttl      (rsp_new_ttl),
   .rsp_new_checksum (rsp_new_checksum)
);
